// ===== design/mp4_box_path_locator_core_assert.svh =====
// Assertion macros for the MP4 box path locator.
// Expects clk and rst_n in the scope of the including module.
`ifndef MP4_BOX_PATH_LOCATOR_CORE_ASSERT_SVH
`define MP4_BOX_PATH_LOCATOR_CORE_ASSERT_SVH

// check at every edge outside reset
`define MBPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge, reset included
`define MBPL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mbpl_pkg.sv =====
// Shared types and constants of the MP4 box path locator.
// No dependencies.
`default_nettype none

package mbpl_pkg;

  localparam logic [31:0] TYPE_MOOV         = 32'h6D6F_6F76;
  localparam logic [31:0] TYPE_UDTA         = 32'h7564_7461;
  localparam logic [31:0] LEAF_TAG_RST      = 32'h4355_5354;
  localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd256;
  localparam logic [31:0] HDR_LEN           = 32'd8;
  localparam int          CFG_IDX_W         = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAF_TAG      = 4'd0,
    CFG_PAYLOAD_LIMIT = 4'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_PAYLOAD   = 3'd0,
    ST_NO_MOOV   = 3'd1,
    ST_NO_UDTA   = 3'd2,
    ST_NO_LEAF   = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_TRUNCATED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    LVL_TOP     = 2'd0,
    LVL_MOOV    = 2'd1,
    LVL_UDTA    = 2'd2,
    LVL_PAYLOAD = 2'd3
  } level_t;

  typedef struct packed {
    logic [31:0] leaf_tag;
    logic [15:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    status_t    status;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== design/mbpl_if.sv =====
// Channel interfaces of the MP4 box path locator: file bytes, results, config.
// Depends on mbpl_pkg.
`default_nettype none

interface mbpl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface mbpl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [2:0] out_status;
  modport source (output valid, output out_byte, output out_last, output out_status,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input out_status,
                output ready);
endinterface

interface mbpl_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mbpl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0]                    cfg_data;
  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink (input valid, input cfg_index, input cfg_data, output ready);
endinterface

`default_nettype wire

// ===== design/mbpl_cfg_regs.sv =====
// Configuration registers of the MP4 box path locator (leaf tag, payload limit).
// Depends on mbpl_pkg and mbpl_if.
`default_nettype none

module mbpl_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  mbpl_cfg_if.sink            cfg_bus,
  output mbpl_pkg::cfg_t      cfg
);

  mbpl_pkg::cfg_t cfg_r;

  assign cfg_bus.ready = 1'b1;
  assign cfg           = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.leaf_tag      <= mbpl_pkg::LEAF_TAG_RST;
      cfg_r.payload_limit <= mbpl_pkg::PAYLOAD_LIMIT_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.cfg_index)
        mbpl_pkg::CFG_LEAF_TAG:      cfg_r.leaf_tag      <= cfg_bus.cfg_data;
        mbpl_pkg::CFG_PAYLOAD_LIMIT: cfg_r.payload_limit <= cfg_bus.cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/mp4_box_path_locator_core.sv =====
// Top level of the MP4 box path locator: box header walk and payload output.
// Depends on mbpl_pkg, mbpl_if, mbpl_cfg_regs and the assertion macro header.
//
// channel  dir  payload                               beat
// in_bus   in   in_byte[7:0] in_last                  one file byte
// out_bus  out  out_byte[7:0] out_last out_status[2:0] one payload byte or error
// cfg_bus  in   cfg_index[3:0] cfg_data[31:0]         one register write
//
// One byte per cycle unless the result buffer is full; the input register feeds the buffer.
// Byte handling sits between the input register and a two-entry result buffer.
// in_bus.ready drops only while the result buffer is full and the input register holds.
// rst_n is synchronous; config registers return to their defaults, no clearing pass.
`default_nettype none

module mp4_box_path_locator_core (
  input  logic        clk,
  input  logic        rst_n,
  mbpl_in_if.sink     in_bus,
  mbpl_out_if.source  out_bus,
  mbpl_cfg_if.sink    cfg_bus
);

  `include "mp4_box_path_locator_core_assert.svh"

  mbpl_pkg::cfg_t cfg;

  mbpl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  // input register
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       adv;
  logic       in_fire;

  // result buffer
  mbpl_pkg::out_beat_t buf_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          cnt_r;
  logic                full;
  logic                push;
  logic                pop;

  // parse state
  mbpl_pkg::level_t lvl_r, lvl_nxt;
  logic [2:0]       hc_r, hc_nxt;
  logic [31:0]      size_r, size_nxt;
  logic [31:0]      type_r, type_nxt;
  logic [31:0]      skip_r, skip_nxt;
  logic [31:0]      c0_r, c0_nxt;
  logic [31:0]      c1_r, c1_nxt;
  logic [15:0]      pl_r, pl_nxt;
  logic             fin_r, fin_nxt;

  logic                res_v;
  mbpl_pkg::out_beat_t res;
  logic [31:0]         type_new;
  logic [31:0]         body;
  logic [15:0]         pl_dec;

  assign full          = (cnt_r == 2'd2);
  assign adv           = s1_v_r && !full;
  assign in_bus.ready  = !s1_v_r || adv;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign push          = adv && res_v;
  assign pop           = out_bus.valid && out_bus.ready;

  assign type_new = {type_r[23:0], s1_byte_r};
  assign body     = size_r - mbpl_pkg::HDR_LEN;
  assign pl_dec   = pl_r - 16'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_bus.in_byte;
      s1_last_r <= in_bus.in_last;
    end
  end

  always_comb begin
    lvl_nxt    = lvl_r;
    hc_nxt     = hc_r;
    size_nxt   = size_r;
    type_nxt   = type_r;
    skip_nxt   = skip_r;
    c0_nxt     = c0_r;
    c1_nxt     = c1_r;
    pl_nxt     = pl_r;
    fin_nxt    = fin_r;
    res_v      = 1'b0;
    res.data   = 8'd0;
    res.last   = 1'b0;
    res.status = mbpl_pkg::ST_PAYLOAD;

    priority if (!fin_r && lvl_r == mbpl_pkg::LVL_PAYLOAD) begin
      pl_nxt = pl_dec;
      res_v  = 1'b1;
      if (pl_dec == 16'd0) begin
        res.data = s1_byte_r;
        res.last = 1'b1;
        fin_nxt  = 1'b1;
      end else if (s1_last_r) begin
        res.last   = 1'b1;
        res.status = mbpl_pkg::ST_TRUNCATED;
        fin_nxt    = 1'b1;
      end else begin
        res.data = s1_byte_r;
      end
    end else if (!fin_r) begin
      if (lvl_r == mbpl_pkg::LVL_MOOV && c0_r != 32'd0) begin
        c0_nxt = c0_r - 32'd1;
      end else if (lvl_r == mbpl_pkg::LVL_UDTA && c1_r != 32'd0) begin
        c1_nxt = c1_r - 32'd1;
      end

      if (skip_r != 32'd0) begin
        skip_nxt = skip_r - 32'd1;
      end else begin
        if (!hc_r[2]) begin
          size_nxt = {size_r[23:0], s1_byte_r};
        end else begin
          type_nxt = type_new;
        end
        hc_nxt = hc_r + 3'd1;
        if (hc_r == 3'd7) begin
          if (size_r < mbpl_pkg::HDR_LEN) begin
            res_v      = 1'b1;
            res.last   = 1'b1;
            res.status = mbpl_pkg::ST_BAD_SIZE;
            fin_nxt    = 1'b1;
          end else if (lvl_r == mbpl_pkg::LVL_TOP && type_new == mbpl_pkg::TYPE_MOOV) begin
            lvl_nxt = mbpl_pkg::LVL_MOOV;
            c0_nxt  = body;
          end else if (lvl_r == mbpl_pkg::LVL_MOOV && type_new == mbpl_pkg::TYPE_UDTA) begin
            lvl_nxt = mbpl_pkg::LVL_UDTA;
            c1_nxt  = body;
          end else if (lvl_r == mbpl_pkg::LVL_UDTA && type_new == cfg.leaf_tag) begin
            if (body > {16'd0, cfg.payload_limit}) begin
              res_v      = 1'b1;
              res.last   = 1'b1;
              res.status = mbpl_pkg::ST_TOO_LONG;
              fin_nxt    = 1'b1;
            end else if (body == 32'd0) begin
              fin_nxt = 1'b1;
            end else begin
              lvl_nxt = mbpl_pkg::LVL_PAYLOAD;
              pl_nxt  = body[15:0];
            end
          end else begin
            skip_nxt = body;
          end
        end
      end

      if (!fin_nxt) begin
        if (lvl_nxt == mbpl_pkg::LVL_MOOV && c0_nxt == 32'd0) begin
          res_v      = 1'b1;
          res.last   = 1'b1;
          res.status = mbpl_pkg::ST_NO_UDTA;
          fin_nxt    = 1'b1;
        end else if (lvl_nxt == mbpl_pkg::LVL_UDTA && c1_nxt == 32'd0) begin
          res_v      = 1'b1;
          res.last   = 1'b1;
          res.status = mbpl_pkg::ST_NO_LEAF;
          fin_nxt    = 1'b1;
        end else if (s1_last_r) begin
          res_v    = 1'b1;
          res.last = 1'b1;
          fin_nxt  = 1'b1;
          unique case (lvl_nxt)
            mbpl_pkg::LVL_TOP:     res.status = mbpl_pkg::ST_NO_MOOV;
            mbpl_pkg::LVL_MOOV:    res.status = mbpl_pkg::ST_NO_UDTA;
            mbpl_pkg::LVL_UDTA:    res.status = mbpl_pkg::ST_NO_LEAF;
            mbpl_pkg::LVL_PAYLOAD: res.status = mbpl_pkg::ST_TRUNCATED;
          endcase
        end
      end
    end else begin
      fin_nxt = 1'b1;
    end

    // file boundary: start over
    if (s1_last_r) begin
      lvl_nxt  = mbpl_pkg::LVL_TOP;
      hc_nxt   = 3'd0;
      size_nxt = 32'd0;
      type_nxt = 32'd0;
      skip_nxt = 32'd0;
      c0_nxt   = 32'd0;
      c1_nxt   = 32'd0;
      pl_nxt   = 16'd0;
      fin_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r  <= mbpl_pkg::LVL_TOP;
      hc_r   <= 3'd0;
      size_r <= 32'd0;
      type_r <= 32'd0;
      skip_r <= 32'd0;
      c0_r   <= 32'd0;
      c1_r   <= 32'd0;
      pl_r   <= 16'd0;
      fin_r  <= 1'b0;
    end else if (adv) begin
      lvl_r  <= lvl_nxt;
      hc_r   <= hc_nxt;
      size_r <= size_nxt;
      type_r <= type_nxt;
      skip_r <= skip_nxt;
      c0_r   <= c0_nxt;
      c1_r   <= c1_nxt;
      pl_r   <= pl_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_bus.valid      = (cnt_r != 2'd0);
  assign out_bus.out_byte   = buf_r[rd_ptr_r].data;
  assign out_bus.out_last   = buf_r[rd_ptr_r].last;
  assign out_bus.out_status = buf_r[rd_ptr_r].status;

  `MBPL_ASSERT(a_buf_bound, cnt_r != 2'd3, "result buffer count out of range")
  `MBPL_ASSERT(a_fin_quiet, adv && fin_r |-> !res_v, "result produced after finish")
  `MBPL_ASSERT(a_err_shape,
    res_v && res.status != mbpl_pkg::ST_PAYLOAD |-> res.last && res.data == 8'd0,
    "error result with payload data")
  `MBPL_ASSERT(a_eof_clear,
    adv && s1_last_r |=> lvl_r == mbpl_pkg::LVL_TOP && hc_r == 3'd0 && !fin_r,
    "state not cleared at file end")
  `MBPL_ASSERT(a_pl_live,
    !fin_r && lvl_r == mbpl_pkg::LVL_PAYLOAD |-> pl_r != 16'd0,
    "payload level with nothing left")
  `MBPL_ASSERT_RST(a_rst_empty, !rst_n |=> cnt_r == 2'd0 && !s1_v_r,
    "pipeline not empty after reset")

endmodule

`default_nettype wire
